@@ src/sem_pkg.sv @@
// sem_pkg: types and constants shared by the standard error of mean block.
// No dependencies.
`timescale 1ns / 1ps
package sem_pkg;

  localparam int SAMPLE_W = 24;
  localparam int INDEX_W  = 6;
  localparam int DEV_W    = 25;
  localparam int DSQ_W    = 33;
  localparam int SSQ_W    = 38;
  localparam int SIGMA_W  = 27;
  localparam int SUM_W    = 30;

  localparam logic KIND_ROW     = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic load;
    logic clear;
    logic div_start;
    logic set_mean;
    logic rd_start;
    logic sum_load;
    logic sqrt_start;
    logic sq_div_start;
  } sem_cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic row_busy;
    logic rows_done;
    logic single;
  } sem_status_t;

endpackage

@@ src/standard_error_of_mean.sv @@
// standard_error_of_mean: top level joining controller and datapath.
// Depends on sem_pkg, sem_ctrl, sem_dp, sem_ram.
//
// Usage: samples enter on the s_axis channel (tdata = sample, tlast marks
// the final sample of a set), one word per cycle while loading. After the
// last word the block stops taking input, divides the sum by the count
// (an iterative divider, 54 steps), and then starts the row pass. It emits
// one row word per stored sample on m_axis, each read from the store and
// squared in the multiplier register before the next is read, then
// divides the sum of squares (54 steps) and takes its square root
// (28 steps), emitting the summary word with tlast high after the
// last row word. Input is taken again once the summary word is loaded
// and the set is cleared. Samples beyond MAX_SAMPLES are dropped and flagged.
// A stalled receiver holds the output register and the row pass waits.
// Reset (rst, synchronous) empties the set and drops any pending word.
`timescale 1ns / 1ps
module standard_error_of_mean import sem_pkg::*; #(
  parameter int MAX_SAMPLES = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // sample[23:0]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // index[5:0], value[29:6], deviation[54:30], deviation_sq[87:55],
  // mean[111:88], sum_sq[149:112], sigma[176:150], sigma_valid[177],
  // overflow[178], zero fill to 183
  output logic [183:0] m_axis_tdata,
  output logic         m_axis_tuser,  // kind
  output logic         m_axis_tlast   // end_of_run
);
  sem_cmd_t    cmd;
  sem_status_t status;
  logic        in_fire, out_free;
  logic        kind, sigma_valid, overflow;
  logic [INDEX_W-1:0]         index;
  logic signed [SAMPLE_W-1:0] value, mean;
  logic signed [DEV_W-1:0]    deviation;
  logic [DSQ_W-1:0]           deviation_sq;
  logic [SSQ_W-1:0]           sum_sq;
  logic [SIGMA_W-1:0]         sigma;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  sem_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_axis_tlast), .out_free,
    .status, .cmd, .in_ready(s_axis_tready)
  );

  sem_dp #(.MAX_SAMPLES(MAX_SAMPLES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status, .sample(s_axis_tdata),
    .out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_free,
    .kind, .index, .value, .deviation, .deviation_sq, .mean, .sum_sq,
    .sigma, .sigma_valid, .overflow, .end_of_run(m_axis_tlast)
  );

  assign m_axis_tuser = kind;
  assign m_axis_tdata = {5'b0, overflow, sigma_valid, sigma, sum_sq, mean,
                         deviation_sq, deviation, value, index};

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready || m_axis_tuser == KIND_SUMMARY)
    else $error("input taken while rows pending");
  a_last_summary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == m_axis_tuser))
    else $error("tlast not on summary");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("word dropped under stall");
endmodule

@@ src/sem_ram.sv @@
// sem_ram: generic single-port write, single read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/sem_ctrl.sv @@
// sem_ctrl: sequencer for load, mean, row pass and sigma phases.
// Depends on sem_pkg.
`timescale 1ns / 1ps
module sem_ctrl import sem_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_fire,
  input  logic        in_last,
  input  logic        out_free,
  input  sem_status_t status,
  output sem_cmd_t    cmd,
  output logic        in_ready
);
  typedef enum logic [7:0] {
    S_LOAD  = 8'b00000001,
    S_START = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_ROWS  = 8'b00001000,
    S_SQDIV = 8'b00010000,
    S_SQRT  = 8'b00100000,
    S_SUM   = 8'b01000000,
    S_WAIT  = 8'b10000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire && in_last) begin
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          cmd.set_mean = 1'b1;
          cmd.rd_start = 1'b1;
          state_next = S_ROWS;
        end
      end
      S_ROWS: begin
        if (status.rows_done && !status.row_busy) begin
          cmd.sq_div_start = 1'b1;
          state_next = S_SQDIV;
        end
      end
      S_SQDIV: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        if (status.sqrt_done) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (out_free) begin
          cmd.sum_load = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        cmd.clear = 1'b1;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end
endmodule

@@ src/sem_dp.sv @@
// sem_dp: sample store, sum, shared restoring divider, row pass,
// square root and output register. Depends on sem_pkg and sem_ram.
`timescale 1ns / 1ps
module sem_dp import sem_pkg::*; #(
  parameter int MAX_SAMPLES = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  sem_cmd_t                   cmd,
  output sem_status_t                status,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_free,
  output logic                       kind,
  output logic [INDEX_W-1:0]         index,
  output logic signed [SAMPLE_W-1:0] value,
  output logic signed [DEV_W-1:0]    deviation,
  output logic [DSQ_W-1:0]           deviation_sq,
  output logic signed [SAMPLE_W-1:0] mean,
  output logic [SSQ_W-1:0]           sum_sq,
  output logic [SIGMA_W-1:0]         sigma,
  output logic                       sigma_valid,
  output logic                       overflow,
  output logic                       end_of_run
);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int DIVW  = SSQ_W + FRAC_BITS;
  localparam int DENW  = 2 * INDEX_W;
  localparam int DCW   = $clog2(DIVW + 1);
  localparam int PRODW = 2 * DEV_W;
  localparam int SQW   = DIVW + 2;
  localparam int SQIT  = SQW / 2;
  localparam int SCW   = $clog2(SQIT + 1);

  logic [INDEX_W-1:0]         count;
  logic signed [SUM_W-1:0]    rsum;
  logic                       dropped;
  logic                       full;
  logic [SAMPLE_W-1:0]        rdata;
  logic [AW-1:0]              raddr;

  assign full = (count == INDEX_W'(MAX_SAMPLES));

  sem_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_SAMPLES)) u_ram (
    .clk  (clk),
    .we   (cmd.load && !full),
    .waddr(count[AW-1:0]),
    .wdata(sample),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      rsum <= '0;
      dropped <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        dropped <= 1'b1;
      end else begin
        count <= count + 1'b1;
        rsum <= rsum + SUM_W'(sample);
      end
    end
  end

  // Shared restoring divider on magnitudes.
  logic [DIVW-1:0]  dq;
  logic [DIVW:0]    drem;
  logic [DENW-1:0]  dden;
  logic [DCW-1:0]   dcnt;
  logic             dbusy, dneg, ddone;
  logic [DIVW:0]    dtrial;
  logic [SUM_W-1:0] abs_sum;
  logic [SSQ_W-1:0] ssq;

  assign abs_sum = rsum[SUM_W-1] ? SUM_W'(-rsum) : SUM_W'(rsum);
  assign dtrial  = {drem[DIVW-1:0], dq[DIVW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      dbusy <= 1'b0;
      ddone <= 1'b0;
    end else begin
      ddone <= 1'b0;
      if (cmd.div_start || cmd.sq_div_start) begin
        dbusy <= 1'b1;
        dcnt  <= DCW'(DIVW);
        drem  <= '0;
        if (cmd.div_start) begin
          dq   <= DIVW'(abs_sum) + DIVW'(0);
          dneg <= rsum[SUM_W-1];
          dden <= DENW'(count);
        end else begin
          dq   <= {ssq, FRAC_BITS'(0)};
          dneg <= 1'b0;
          dden <= DENW'(count) * DENW'(count - 1'b1);
        end
      end else if (dbusy) begin
        if (dtrial >= (DIVW+1)'(dden)) begin
          drem <= dtrial - (DIVW+1)'(dden);
          dq   <= {dq[DIVW-2:0], 1'b1};
        end else begin
          drem <= dtrial;
          dq   <= {dq[DIVW-2:0], 1'b0};
        end
        dcnt <= dcnt - 1'b1;
        if (dcnt == DCW'(1)) begin
          dbusy <= 1'b0;
          ddone <= 1'b1;
        end
      end
    end
  end

  logic signed [SAMPLE_W-1:0] mean_r;
  always_ff @(posedge clk) begin
    if (cmd.set_mean) begin
      mean_r <= dneg ? SAMPLE_W'(-dq) : SAMPLE_W'(dq);
    end
  end

  // Row pass: read, multiply, then emit.
  logic [INDEX_W-1:0]         ridx;
  logic                       rd_act, rd_pend, row_act;
  logic [INDEX_W-1:0]         p_idx, pp_idx;
  logic signed [SAMPLE_W-1:0] p_val;
  logic signed [DEV_W-1:0]    p_dev;
  logic [DEV_W-1:0]           p_abs;
  logic [PRODW-1:0]           p_prod;
  logic signed [DEV_W-1:0]    dev_c;
  logic [SSQ_W+1:0]           ssq_add;
  logic [PRODW-1:0]           dsq_full;
  logic                       prod_ok, row_emit;

  assign raddr   = ridx[AW-1:0];
  assign dev_c   = DEV_W'(mean_r) - DEV_W'(signed'(rdata));
  assign dsq_full = p_prod >> FRAC_BITS;
  assign out_free = !out_valid || out_ready;
  assign ssq_add = (SSQ_W+2)'(ssq) + (SSQ_W+2)'(dsq_full);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      rd_act  <= 1'b0;
      rd_pend <= 1'b0;
      row_act <= 1'b0;
      ssq     <= '0;
    end else begin
      if (cmd.rd_start) begin
        rd_act <= 1'b1;
        ridx   <= '0;
        ssq    <= '0;
      end else if (rd_act && !rd_pend && !row_act) begin
        rd_pend <= 1'b1;
      end else if (rd_pend) begin
        rd_pend <= 1'b0;
        row_act <= 1'b1;
        p_idx   <= ridx + 1'b1;
        p_val   <= rdata;
        p_dev   <= dev_c;
        p_abs   <= dev_c[DEV_W-1] ? DEV_W'(-dev_c) : DEV_W'(dev_c);
        ridx    <= ridx + 1'b1;
        if (ridx + 1'b1 == count) begin
          rd_act <= 1'b0;
        end
      end
      if (row_act && !rd_pend) begin
        p_prod <= PRODW'(p_abs) * PRODW'(p_abs);
        pp_idx <= p_idx;
      end
      if (row_emit) begin
        row_act <= 1'b0;
        ssq <= (ssq_add > (SSQ_W+2)'({SSQ_W{1'b1}})) ? {SSQ_W{1'b1}}
               : ssq_add[SSQ_W-1:0];
      end
    end
  end

  // Product is ready in the cycle after row_act; track with a flag.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      prod_ok <= 1'b0;
    end else begin
      prod_ok <= row_act && !row_emit && !rd_pend;
    end
  end
  assign row_emit = row_act && prod_ok && out_free;

  // Square root, two bits a step.
  logic [SQW-1:0]     sx, sres, sbit;
  logic [SCW-1:0]     scnt;
  logic               sbusy, sdone;
  always_ff @(posedge clk) begin
    if (rst) begin
      sbusy <= 1'b0;
      sdone <= 1'b0;
    end else begin
      sdone <= 1'b0;
      if (cmd.sqrt_start) begin
        sbusy <= 1'b1;
        sx    <= SQW'(dq);
        sres  <= '0;
        sbit  <= SQW'(1) << (2 * (SQIT - 1));
        scnt  <= SCW'(SQIT);
      end else if (sbusy) begin
        if (sx >= sres + sbit) begin
          sx   <= sx - (sres + sbit);
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
        scnt <= scnt - 1'b1;
        if (scnt == SCW'(1)) begin
          sbusy <= 1'b0;
          sdone <= 1'b1;
        end
      end
    end
  end

  assign status.div_done  = ddone;
  assign status.sqrt_done = sdone;
  assign status.row_busy  = row_act || rd_pend;
  assign status.rows_done = !rd_act;
  assign status.single    = (count < INDEX_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (row_emit) begin
        out_valid    <= 1'b1;
        kind         <= KIND_ROW;
        index        <= pp_idx;
        value        <= p_val;
        deviation    <= p_dev;
        deviation_sq <= (dsq_full > PRODW'({DSQ_W{1'b1}})) ? {DSQ_W{1'b1}}
                        : dsq_full[DSQ_W-1:0];
        mean         <= '0;
        sum_sq       <= '0;
        sigma        <= '0;
        sigma_valid  <= 1'b0;
        overflow     <= 1'b0;
        end_of_run   <= 1'b0;
      end else if (cmd.sum_load) begin
        out_valid    <= 1'b1;
        kind         <= KIND_SUMMARY;
        index        <= '0;
        value        <= '0;
        deviation    <= '0;
        deviation_sq <= '0;
        mean         <= mean_r;
        sum_sq       <= ssq;
        sigma        <= status.single ? '0
                        : ((sres > SQW'({SIGMA_W{1'b1}})) ? {SIGMA_W{1'b1}}
                        : sres[SIGMA_W-1:0]);
        sigma_valid  <= !status.single;
        overflow     <= dropped;
        end_of_run   <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
